// ----- hdl/orbp_pkg.sv -----
// Shared constants, operation codes and structs for the overwrite ring buffer.
package orbp_pkg;

    // buffer geometry
    localparam int DEPTH  = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int BYTE_W = 8;
    localparam int OFS_W  = 5;
    localparam int FILL_W = 5;

    // packed word widths
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    // slot store access for one operation
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic [IDX_W-1:0]  rd_addr;
    } mem_req_t;

    // status fields of one result word
    typedef struct packed {
        logic              read_valid;
        logic              underflow;
        logic [FILL_W-1:0] fill_count;
        logic              is_empty;
        logic [FILL_W-1:0] high_water;
    } status_t;

endpackage

// ----- hdl/orbp_store.sv -----
// Byte slot store: one write port, one registered read port.
module orbp_store (
    input  logic                                aclk,
    input  logic                                rd_en,
    input  orbp_pkg::mem_req_t                  req,
    output logic [orbp_pkg::BYTE_W-1:0]         rd_data
);

    logic [orbp_pkg::BYTE_W-1:0] mem [orbp_pkg::DEPTH];
    logic [orbp_pkg::BYTE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // read port, held while the result word stalls
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/orbp_ctrl.sv -----
// Ring pointers, high-water mark and per-operation result status.
module orbp_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  orbp_pkg::op_t                 op,
    input  logic [orbp_pkg::BYTE_W-1:0]   push_byte,
    input  logic [orbp_pkg::OFS_W-1:0]    peek_offset,
    output orbp_pkg::mem_req_t            mem_req,
    output orbp_pkg::status_t             status
);

    localparam int IW = orbp_pkg::IDX_W;
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(orbp_pkg::DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(orbp_pkg::DEPTH - 1);

    logic [IW-1:0] oldest_reg, oldest_next;
    logic [IW-1:0] wr_idx_reg, wr_idx_next;
    logic [IW-1:0] peak_reg,   peak_next;

    logic [IW-1:0] fill_now, fill_after;
    logic [IW-1:0] wr_adv, old_adv, peek_pos;
    logic [CW-1:0] pos_sum;
    logic          peek_ok;

    function automatic logic [IW-1:0] fill_of(input logic [IW-1:0] wr,
                                             input logic [IW-1:0] rd);
        logic [CW-1:0] diff;
        if (wr >= rd) begin
            diff = {1'b0, wr} - {1'b0, rd};
        end else begin
            diff = DEPTH_C + {1'b0, wr} - {1'b0, rd};
        end
        return diff[IW-1:0];
    endfunction

    // pointer increments with wrap
    assign wr_adv  = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
    assign old_adv = (oldest_reg == LAST_IDX) ? '0 : oldest_reg + 1'b1;
    assign fill_now = fill_of(wr_idx_reg, oldest_reg);

    // peek address and range check
    assign pos_sum  = {1'b0, oldest_reg} + CW'(peek_offset);
    assign peek_pos = (pos_sum >= DEPTH_C) ? IW'(pos_sum - DEPTH_C) : pos_sum[IW-1:0];
    assign peek_ok  = CW'(peek_offset) < {1'b0, fill_now};

    // next state and status for the current operation
    always_comb begin
        oldest_next       = oldest_reg;
        wr_idx_next       = wr_idx_reg;
        peak_next         = peak_reg;
        mem_req.wr_en     = 1'b0;
        mem_req.wr_addr   = wr_idx_reg;
        mem_req.wr_data   = push_byte;
        mem_req.rd_addr   = oldest_reg;
        status.read_valid = 1'b0;
        status.underflow  = 1'b0;
        unique case (op)
            orbp_pkg::OP_PUSH: begin
                mem_req.wr_en = accept;
                wr_idx_next   = wr_adv;
                if (wr_adv == oldest_reg) begin
                    oldest_next = old_adv;
                end else if (fill_now + 1'b1 > peak_reg) begin
                    peak_next = fill_now + 1'b1;
                end
            end
            orbp_pkg::OP_POP: begin
                if (fill_now == '0) begin
                    status.underflow = 1'b1;
                end else begin
                    status.read_valid = 1'b1;
                    oldest_next       = old_adv;
                end
            end
            orbp_pkg::OP_PEEK: begin
                mem_req.rd_addr   = peek_pos;
                status.read_valid = peek_ok;
            end
            orbp_pkg::OP_CLEAR: begin
                oldest_next = '0;
                wr_idx_next = '0;
            end
            default: begin
                oldest_next = oldest_reg;
            end
        endcase
        fill_after        = fill_of(wr_idx_next, oldest_next);
        status.fill_count = orbp_pkg::FILL_W'(fill_after);
        status.is_empty   = (fill_after == '0);
        status.high_water = orbp_pkg::FILL_W'(peak_next);
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_reg <= '0;
            wr_idx_reg <= '0;
            peak_reg   <= '0;
        end else if (accept) begin
            oldest_reg <= oldest_next;
            wr_idx_reg <= wr_idx_next;
            peak_reg   <= peak_next;
        end
    end

endmodule

// ----- hdl/overwrite_ring_buffer_with_peek.sv -----
// Top level: byte ring buffer with overwrite of the oldest byte, peek and high-water mark.
// The result word of an accepted input word is registered and appears on m_tdata in the following cycle.
// Throughput: one operation per cycle; the only limit is the result register draining.
// Each accepted operation updates the pointers it needs and does a registered slot read; a push also writes one slot.
// Reset (aresetn low, synchronous): pointers, high-water mark and m_tvalid clear.
// Slot contents are not reset; only slots written by a push are ever returned.
module overwrite_ring_buffer_with_peek (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // operation[1:0], push_byte[9:2], peek_offset[14:10], zero[15]
    input  logic [orbp_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // read_byte[7:0], read_valid[8], underflow[9], fill_count[14:10],
    // is_empty[15], high_water[20:16], zero[23:21]
    output logic [orbp_pkg::M_DATA_W-1:0]     m_tdata
);

    logic                         accept;
    orbp_pkg::mem_req_t           mem_req;
    orbp_pkg::status_t            status;
    orbp_pkg::status_t            status_reg;
    logic                         m_tvalid_reg;
    logic [orbp_pkg::BYTE_W-1:0]  rd_data;
    logic [orbp_pkg::BYTE_W-1:0]  read_byte;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    orbp_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .op          (orbp_pkg::op_t'(s_tdata[1:0])),
        .push_byte   (s_tdata[9:2]),
        .peek_offset (s_tdata[14:10]),
        .mem_req     (mem_req),
        .status      (status)
    );

    orbp_store u_store (
        .aclk    (aclk),
        .rd_en   (accept),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status;
        end
    end

    // a read that returned nothing shows zero
    assign read_byte = status_reg.read_valid ? rd_data : '0;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {3'b000, status_reg.high_water, status_reg.is_empty,
                        status_reg.fill_count, status_reg.underflow,
                        status_reg.read_valid, read_byte};

endmodule

// ----- hdl/orbp_checker.sv -----
// Port-level checker for the ring buffer, bound to the top level.
module orbp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [orbp_pkg::S_DATA_W-1:0]  s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [orbp_pkg::M_DATA_W-1:0]  m_tdata
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // empty flag agrees with fill count
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15] == (m_tdata[14:10] == 5'd0)))
        else $error("is_empty disagrees with fill_count");

    // high-water mark never below the fill count
    a_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[20:16] >= m_tdata[14:10]))
        else $error("high_water below fill_count");

    // a failed or absent read returns zero and never both flags
    a_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[8] && m_tdata[9]) && (m_tdata[8] || m_tdata[7:0] == 8'd0))
        else $error("read flags or byte inconsistent");

    // an accepted pop on a word with nothing held reports underflow
    a_under: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tdata[15] && s_tvalid && s_tready
        && s_tdata[1:0] == orbp_pkg::OP_POP |=> m_tdata[9] && m_tdata[15])
        else $error("pop on empty buffer without underflow");

endmodule

bind overwrite_ring_buffer_with_peek orbp_checker u_orbp_checker (.*);

// ----- verif/overwrite_ring_buffer_with_peek_test.sv -----
// Self-checking testbench for the overwrite ring buffer: directed and random operations.
module overwrite_ring_buffer_with_peek_test;
    timeunit 1ns;
    timeprecision 1ps;

    // expected content of one result word
    typedef struct packed {
        logic [orbp_pkg::BYTE_W-1:0] read_byte;
        logic                        read_valid;
        logic                        underflow;
        logic [orbp_pkg::FILL_W-1:0] fill_count;
        logic                        is_empty;
        logic [orbp_pkg::FILL_W-1:0] high_water;
    } ring_status_t;

    logic                          aclk;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [orbp_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [orbp_pkg::M_DATA_W-1:0] m_tdata;

    // shadow copy of the ring
    logic [orbp_pkg::BYTE_W-1:0] ring_slots [orbp_pkg::DEPTH];
    logic [orbp_pkg::IDX_W-1:0]  ring_head;
    logic [orbp_pkg::IDX_W-1:0]  ring_tail;
    logic [orbp_pkg::FILL_W-1:0] ring_peak;

    ring_status_t pending_status [$];
    ring_status_t got_status;

    int fail_count    = 0;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int rx_cycle      = 0;
    int rx_hold_until = 0;
    int op_count [4]  = '{0, 0, 0, 0};
    int overwrite_count = 0;
    int underflow_count = 0;
    int peek_miss_count = 0;
    int words_checked   = 0;

    overwrite_ring_buffer_with_peek uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // bytes held, from the two indices (5-bit wrap matches DEPTH)
    function automatic logic [orbp_pkg::FILL_W-1:0] ring_fill();
        return orbp_pkg::FILL_W'(ring_tail - ring_head);
    endfunction

    // apply one operation to the shadow ring and return the status it reports
    function automatic ring_status_t apply_ring_op(orbp_pkg::op_t op,
                                                   logic [orbp_pkg::BYTE_W-1:0] data,
                                                   logic [orbp_pkg::OFS_W-1:0] ofs);
        ring_status_t st;
        st = '0;
        case (op)
            orbp_pkg::OP_PUSH: begin
                ring_slots[ring_tail] = data;
                ring_tail = ring_tail + 1'b1;
                if (ring_tail == ring_head) begin
                    // full: oldest byte is dropped
                    ring_head = ring_head + 1'b1;
                    overwrite_count++;
                end else if (ring_fill() > ring_peak) begin
                    ring_peak = ring_fill();
                end
            end
            orbp_pkg::OP_POP: begin
                if (ring_fill() == 0) begin
                    st.underflow = 1'b1;
                    underflow_count++;
                end else begin
                    st.read_byte  = ring_slots[ring_head];
                    st.read_valid = 1'b1;
                    ring_head = ring_head + 1'b1;
                end
            end
            orbp_pkg::OP_PEEK: begin
                if (ofs < ring_fill()) begin
                    st.read_byte  = ring_slots[orbp_pkg::IDX_W'(ring_head + ofs)];
                    st.read_valid = 1'b1;
                end else begin
                    peek_miss_count++;
                end
            end
            default: begin
                ring_head = '0;
                ring_tail = '0;
            end
        endcase
        st.fill_count = ring_fill();
        st.is_empty   = (ring_fill() == 0);
        st.high_water = ring_peak;
        return st;
    endfunction

    task automatic note_fail(string what, int exp_v, int act_v);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t mismatch %s: expected 0x%0h, got 0x%0h",
                     $realtime, what, exp_v, act_v);
    endtask

    // send one word; idles first at the current sender rate, predicts on acceptance
    task automatic send_word(orbp_pkg::op_t op, logic [orbp_pkg::BYTE_W-1:0] data,
                             logic [orbp_pkg::OFS_W-1:0] ofs);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, ofs, data, op};
        do @(posedge aclk); while (!s_tready);
        pending_status.push_back(apply_ring_op(op, data, ofs));
        op_count[op]++;
    endtask

    // receiver: random stalls plus a long hold-off window
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        m_tready <= (rx_cycle >= rx_hold_until) && ($urandom_range(99) >= rx_idle_pct);
    end

    // compare each accepted result word with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_status.size() == 0) begin
                note_fail("unexpected result word", 0, int'(m_tdata));
            end else begin
                got_status = pending_status.pop_front();
                words_checked++;
                if (got_status.read_byte != m_tdata[7:0])
                    note_fail("read_byte", int'(got_status.read_byte), int'(m_tdata[7:0]));
                if (got_status.read_valid != m_tdata[8])
                    note_fail("read_valid", int'(got_status.read_valid), int'(m_tdata[8]));
                if (got_status.underflow != m_tdata[9])
                    note_fail("underflow", int'(got_status.underflow), int'(m_tdata[9]));
                if (got_status.fill_count != m_tdata[14:10])
                    note_fail("fill_count", int'(got_status.fill_count),
                              int'(m_tdata[14:10]));
                if (got_status.is_empty != m_tdata[15])
                    note_fail("is_empty", int'(got_status.is_empty), int'(m_tdata[15]));
                if (got_status.high_water != m_tdata[20:16])
                    note_fail("high_water", int'(got_status.high_water),
                              int'(m_tdata[20:16]));
            end
        end
    end

    // operations on a buffer that has never held anything
    task automatic test_empty_buffer();
        send_word(orbp_pkg::OP_POP,   8'h00, 5'd0);
        send_word(orbp_pkg::OP_PEEK,  8'hFF, 5'd0);
        send_word(orbp_pkg::OP_PEEK,  8'h00, 5'd31);
        send_word(orbp_pkg::OP_CLEAR, 8'hFF, 5'd31);
    endtask

    // small fill: value extremes, peeks in and beyond range, drain past empty, clear
    task automatic test_push_peek_pop();
        send_word(orbp_pkg::OP_PUSH,  8'h00, 5'd31);
        send_word(orbp_pkg::OP_PUSH,  8'hFF, 5'd0);
        send_word(orbp_pkg::OP_PUSH,  8'hA5, 5'd0);
        send_word(orbp_pkg::OP_PEEK,  8'h00, 5'd0);
        send_word(orbp_pkg::OP_PEEK,  8'h00, 5'd2);
        send_word(orbp_pkg::OP_PEEK,  8'h00, 5'd3);
        send_word(orbp_pkg::OP_POP,   8'hFF, 5'd0);
        send_word(orbp_pkg::OP_POP,   8'h00, 5'd0);
        send_word(orbp_pkg::OP_POP,   8'h00, 5'd0);
        send_word(orbp_pkg::OP_POP,   8'h00, 5'd0);
        send_word(orbp_pkg::OP_PUSH,  8'h3C, 5'd0);
        send_word(orbp_pkg::OP_CLEAR, 8'h00, 5'd0);
        send_word(orbp_pkg::OP_PEEK,  8'h00, 5'd0);
    endtask

    // fill past capacity so pushes drop the oldest byte and indices wrap
    task automatic test_wrap_and_overwrite();
        repeat (40) send_word(orbp_pkg::OP_PUSH, 8'($urandom_range(255)),
                              5'($urandom_range(31)));
        send_word(orbp_pkg::OP_PEEK, 8'h00, 5'd30);
        send_word(orbp_pkg::OP_PEEK, 8'h00, 5'd31);
        send_word(orbp_pkg::OP_POP,  8'h00, 5'd0);
        send_word(orbp_pkg::OP_PUSH, 8'h81, 5'd0);
        send_word(orbp_pkg::OP_PEEK, 8'h00, 5'd30);
    endtask

    // receiver holds off for a long window while the sender keeps offering
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_until <= rx_cycle + 300;
        repeat (40) send_word(orbp_pkg::OP_PUSH, 8'($urandom_range(255)),
                              5'($urandom_range(31)));
        repeat (10) send_word(orbp_pkg::OP_POP, 8'($urandom_range(255)),
                              5'($urandom_range(31)));
    endtask

    // random operations, biased in stretches toward filling, draining or mixed use
    task automatic test_random_ops(int count, int tx_pct, int rx_pct);
        int   trend;
        int   roll;
        orbp_pkg::op_t op;
        logic [orbp_pkg::OFS_W-1:0] ofs;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        trend = 0;
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0)
                trend = $urandom_range(2);
            roll = $urandom_range(99);
            case (trend)
                0:       op = (roll < 65) ? orbp_pkg::OP_PUSH : (roll < 80) ? orbp_pkg::OP_POP :
                              (roll < 98) ? orbp_pkg::OP_PEEK : orbp_pkg::OP_CLEAR;
                1:       op = (roll < 20) ? orbp_pkg::OP_PUSH : (roll < 75) ? orbp_pkg::OP_POP :
                              (roll < 98) ? orbp_pkg::OP_PEEK : orbp_pkg::OP_CLEAR;
                default: op = (roll < 40) ? orbp_pkg::OP_PUSH : (roll < 70) ? orbp_pkg::OP_POP :
                              (roll < 98) ? orbp_pkg::OP_PEEK : orbp_pkg::OP_CLEAR;
            endcase
            // peek offsets mostly within the fill, up to one past it, sometimes anywhere
            if ($urandom_range(3) == 0)
                ofs = 5'($urandom_range(31));
            else
                ofs = 5'($urandom_range(ring_fill()));
            send_word(op, 8'($urandom_range(255)), ofs);
        end
    endtask

    // watchdog
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int waited;
        ring_head = '0;
        ring_tail = '0;
        ring_peak = '0;
        foreach (ring_slots[i]) ring_slots[i] = '0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_buffer();
        test_push_peek_pop();
        test_wrap_and_overwrite();
        test_backpressure();
        test_random_ops(600, 32, 62);
        test_random_ops(600, 62, 32);
        test_random_ops(600, 0, 0);
        s_tvalid <= 1'b0;

        // drain outstanding results
        rx_idle_pct = 0;
        waited = 0;
        while (pending_status.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (5) @(posedge aclk);
        if (pending_status.size() != 0)
            note_fail("results never arrived", 0, pending_status.size());

        $display("Ran %0d push, %0d pop, %0d peek, %0d clear; %0d result words checked.",
                 op_count[orbp_pkg::OP_PUSH], op_count[orbp_pkg::OP_POP],
                 op_count[orbp_pkg::OP_PEEK], op_count[orbp_pkg::OP_CLEAR],
                 words_checked);
        $display("Saw %0d overwrites of the oldest byte, %0d empty pops, %0d out-of-range peeks.",
                 overwrite_count, underflow_count, peek_miss_count);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches in total", fail_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
